// ===== rtl/qdpa_pkg.sv =====
// ----------------------------------------------------------------------------
// qdpa_pkg: shared types and constants
// Widths, register indexes, sequencer states and the control bundle of the
// quantized dot-product accumulator.
// ----------------------------------------------------------------------------
package qdpa_pkg;

	localparam int DATA_W     = 8;    // quantized element and zero point width
	localparam int DIFF_W     = DATA_W + 1;  // value minus zero point
	localparam int SCALE_W    = 22;   // fixed-point scale width
	localparam int DEQ_W      = DIFF_W + SCALE_W;  // dequantized value, signed
	localparam int MUL_W      = 32;   // shared multiplier operand width
	localparam int PROD_W     = 2 * MUL_W;
	localparam int TERM_SHIFT = 16;   // fraction bits dropped from the product
	localparam int SUM_W      = 32;   // running sum and result width
	localparam int LIMIT_LOG2 = 30;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SCALE_W;

	// The clamp bound as a full product-width signed constant.
	localparam logic signed [PROD_W-1:0] SUM_LIMIT = PROD_W'(1) << LIMIT_LOG2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_POINT_A = 3'd0,
		REG_SCALE_A      = 3'd1,
		REG_ZERO_POINT_B = 3'd2,
		REG_SCALE_B      = 3'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL_A = 5'b00010,
		ST_MUL_B = 5'b00100,
		ST_MUL_P = 5'b01000,
		ST_ACC   = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_DEQ_A = 2'd1,
		SEL_DEQ_B = 2'd2,
		SEL_PROD = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     in_ready;  // sequencer is idle and takes a request
		logic     mul_en;    // load the multiplier output register
		mul_sel_t sel;       // operand pair for the multiplier
		logic     save_deq;  // keep the first dequantized value
		logic     acc_en;    // fold the term into the running sum
	} ctrl_t;

endpackage

// ===== rtl/qdpa_mult.sv =====
// ----------------------------------------------------------------------------
// qdpa_mult: shared signed multiplier
// One 32x32 signed multiplier with a registered product, reused for all three
// multiplications of an element pair.
// ----------------------------------------------------------------------------
module qdpa_mult (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [qdpa_pkg::MUL_W-1:0]      op_a,
	input  logic signed [qdpa_pkg::MUL_W-1:0]      op_b,
	output logic signed [qdpa_pkg::PROD_W-1:0]     prod
);
	import qdpa_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
		end
	end

	assign prod = prod_q;

endmodule

// ===== rtl/qdpa_seq.sv =====
// ----------------------------------------------------------------------------
// qdpa_seq: element sequencer
// Steps one element pair through the three multiplier passes and the
// accumulate step.
// ----------------------------------------------------------------------------
module qdpa_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            acc_hold,
	output qdpa_pkg::ctrl_t ctrl
);
	import qdpa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctrl.in_ready = 1'b0;
		ctrl.mul_en   = 1'b0;
		ctrl.sel      = SEL_NONE;
		ctrl.save_deq = 1'b0;
		ctrl.acc_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				ctrl.mul_en = 1'b1;
				ctrl.sel    = SEL_DEQ_A;
				state_d     = ST_MUL_B;
			end
			ST_MUL_B: begin
				ctrl.mul_en   = 1'b1;
				ctrl.sel      = SEL_DEQ_B;
				ctrl.save_deq = 1'b1;
				state_d       = ST_MUL_P;
			end
			ST_MUL_P: begin
				ctrl.mul_en = 1'b1;
				ctrl.sel    = SEL_PROD;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				// A last pair waits here while the previous result is unread.
				if (!acc_hold) begin
					ctrl.acc_en = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/quantized_dot_product_accumulator.sv =====
// ----------------------------------------------------------------------------
// quantized_dot_product_accumulator: int8 quantized dot product
// A request's result is registered in the output register once the sequencer
// has taken it through three passes through the single shared 32x32
// multiplier and one accumulate step; a new pair is taken only when the
// sequencer is back in idle. For a last pair the accumulate step stretches
// while a previous result waits. Reset clears the configuration registers,
// the running sum, the sequencer state and the output valid flag.
// ----------------------------------------------------------------------------
module quantized_dot_product_accumulator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic [qdpa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [qdpa_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Element pair requests.
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [qdpa_pkg::DATA_W-1:0]    a_value,
	input  logic signed [qdpa_pkg::DATA_W-1:0]    b_value,
	input  logic                                  last_element,
	// Dot product results.
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [qdpa_pkg::SUM_W-1:0]     dot_sum
);
	import qdpa_pkg::*;

	// Configuration registers.
	logic signed [DATA_W-1:0]  zero_point_a_q;
	logic        [SCALE_W-1:0] scale_a_q;
	logic signed [DATA_W-1:0]  zero_point_b_q;
	logic        [SCALE_W-1:0] scale_b_q;

	// Per-request operands captured at acceptance, and the first dequantized value.
	logic signed [DIFF_W-1:0] da_q;
	logic signed [DIFF_W-1:0] db_q;
	logic                     last_q;
	logic signed [DEQ_W-1:0]  deq_a_q;

	logic signed [SUM_W-1:0]  running_sum_q;
	logic                     out_valid_q;
	logic signed [SUM_W-1:0]  dot_sum_q;

	ctrl_t                    ctrl;
	logic                     acc_hold;
	logic                     in_fire;
	logic                     out_fire;
	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] term;
	logic signed [PROD_W-1:0] sum_wide;
	logic signed [SUM_W-1:0]  sum_clamped;

	assign in_ready  = ctrl.in_ready;
	assign in_fire   = in_valid && ctrl.in_ready;
	assign out_valid = out_valid_q;
	assign out_fire  = out_valid_q && out_ready;
	assign dot_sum   = dot_sum_q;

	// A last pair cannot complete while the output register holds an
	// unread result that is not being taken in this cycle.
	assign acc_hold = last_q && out_valid_q && !out_ready;

	// Configuration writes; indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_point_a_q <= '0;
			scale_a_q      <= '0;
			zero_point_b_q <= '0;
			scale_b_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ZERO_POINT_A: zero_point_a_q <= cfg_data[DATA_W-1:0];
				REG_SCALE_A:      scale_a_q      <= cfg_data[SCALE_W-1:0];
				REG_ZERO_POINT_B: zero_point_b_q <= cfg_data[DATA_W-1:0];
				REG_SCALE_B:      scale_b_q      <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The zero points are removed as the request is taken, so the multiplier
	// passes see nine-bit signed differences.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			da_q   <= DIFF_W'(a_value) - DIFF_W'(zero_point_a_q);
			db_q   <= DIFF_W'(b_value) - DIFF_W'(zero_point_b_q);
			last_q <= last_element;
		end
		if (ctrl.save_deq) begin
			deq_a_q <= prod[DEQ_W-1:0];
		end
	end

	// Operand selection for the shared multiplier. The first two passes
	// dequantize each element; the third multiplies the two dequantized
	// values, the second of which still sits in the product register.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (ctrl.sel)
			SEL_DEQ_A: begin
				op_a = MUL_W'(da_q);
				op_b = $signed({{(MUL_W-SCALE_W){1'b0}}, scale_a_q});
			end
			SEL_DEQ_B: begin
				op_a = MUL_W'(db_q);
				op_b = $signed({{(MUL_W-SCALE_W){1'b0}}, scale_b_q});
			end
			SEL_PROD: begin
				op_a = MUL_W'(deq_a_q);
				op_b = MUL_W'($signed(prod[DEQ_W-1:0]));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	qdpa_mult u_mult (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	qdpa_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.acc_hold (acc_hold),
		.ctrl     (ctrl)
	);

	// The arithmetic shift floors the fixed-point product. The sum is formed
	// at full width so a large term saturates instead of wrapping.
	assign term     = prod >>> TERM_SHIFT;
	assign sum_wide = PROD_W'(running_sum_q) + term;

	always_comb begin
		if (sum_wide > SUM_LIMIT) begin
			sum_clamped = SUM_LIMIT[SUM_W-1:0];
		end else if (sum_wide < -SUM_LIMIT) begin
			sum_clamped = SUM_W'(-SUM_LIMIT);
		end else begin
			sum_clamped = sum_wide[SUM_W-1:0];
		end
	end

	// Accumulator and output register. A last pair sends the clamped sum to
	// the output and restarts the accumulation from zero. When the old result
	// is taken in the same cycle that a new one completes, the new one stays.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (ctrl.acc_en && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.acc_en) begin
				if (last_q) begin
					running_sum_q <= '0;
				end else begin
					running_sum_q <= sum_clamped;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_en && last_q) begin
			dot_sum_q <= sum_clamped;
		end
	end

	// The running sum never leaves the clamp range.
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(running_sum_q <= SUM_W'(SUM_LIMIT)) &&
		(running_sum_q >= SUM_W'(-SUM_LIMIT)))
		else $error("running sum outside clamp range");

	// After a request is taken the block stays busy for the multiplier passes.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("request accepted during multiplier passes");

	// Completing a last pair emits a result and clears the accumulator.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.acc_en && last_q) |=> (out_valid && running_sum_q == '0))
		else $error("last pair did not emit and clear");

	// A pending result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !(ctrl.acc_en && last_q))
		else $error("pending result overwritten");

endmodule

// ===== tb/sv/quantized_dot_product_accumulator_tb.sv =====
// ----------------------------------------------------------------------------
// quantized_dot_product_accumulator_tb: self-checking bench for the int8 dot product
// Sends element pair requests through the valid/ready port and programs the
// zero points and scales through the write port. A behavioral accumulator in
// the bench predicts every dot sum. A checker compares each accepted result
// with the oldest predicted sum. Directed tests cover the extremes and the
// corner cases. They are followed by random vectors, with random stalls on
// both sides, and by a closing back-to-back stretch.
// ----------------------------------------------------------------------------
module quantized_dot_product_accumulator_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import qdpa_pkg::*;

	// Fixed-point shift and clamp bound of the accumulator.
	localparam int          FRAC_SHIFT   = 16;
	localparam longint      SUM_BOUND    = longint'(1) << 30;
	localparam logic [21:0] SCALE_MAX    = 22'h3F_FFFF;
	// Index space above the last defined register; writes there must be dropped.
	localparam logic [2:0]  REG_UNUSED_LO = 3'd4;
	// Cycles the block may still spend on a request that produces no result.
	localparam int          SETTLE_CYCLES = 10;
	localparam int          CYCLE_LIMIT   = 600000;
	localparam int          TOTAL_PAIRS   = 1550;
	localparam int          TAIL_PAIRS    = 150;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [21:0]         cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic signed [7:0]   a_value;
	logic signed [7:0]   b_value;
	logic                last_element;
	logic                out_valid;
	logic                out_ready;
	logic signed [31:0]  dot_sum;

	quantized_dot_product_accumulator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.a_value      (a_value),
		.b_value      (b_value),
		.last_element (last_element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dot_sum      (dot_sum)
	);

	// Bench copy of the configuration registers and of the running sum.
	logic signed [7:0]   zp_a_copy;
	logic [21:0]         scale_a_copy;
	logic signed [7:0]   zp_b_copy;
	logic [21:0]         scale_b_copy;
	longint              sum_copy;

	// Dot sums that the block still owes, oldest first.
	logic signed [31:0]  expected_sums[$];

	int  error_count;
	int  pairs_sent;
	int  cycle_count;
	// When this flag is clear, neither side inserts idle cycles.
	bit  idle_enabled;
	// The sender idles before a request with odds of one in gap_odds; 0 means never.
	int  gap_odds;

	// The clock runs free from time zero.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. It ends a hung run with a failure.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("[quantized_dot_product_accumulator] ERROR");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Folds one element pair into the bench sum. It queues the dot sum when the
	// pair closes a vector. Both dequantized values stay below 2^30 in
	// magnitude, so their product fits in 64 bits. The arithmetic shift of a
	// signed longint rounds toward minus infinity, as the block must.
	function automatic void accumulate_pair(input logic signed [7:0] a,
			input logic signed [7:0] b, input logic last);
		longint deq_a;
		longint deq_b;
		longint term;
		deq_a = (longint'(a) - longint'(zp_a_copy)) * longint'(scale_a_copy);
		deq_b = (longint'(b) - longint'(zp_b_copy)) * longint'(scale_b_copy);
		term = (deq_a * deq_b) >>> FRAC_SHIFT;
		// The addition is done at full width, so a huge term saturates the sum
		// instead of wrapping it.
		sum_copy = sum_copy + term;
		if (sum_copy > SUM_BOUND)
			sum_copy = SUM_BOUND;
		if (sum_copy < -SUM_BOUND)
			sum_copy = -SUM_BOUND;
		if (last) begin
			expected_sums.push_back(32'(sum_copy));
			sum_copy = 0;
		end
	endfunction

	// Register write. The block is idle whenever this is called.
	task automatic write_reg(input logic [2:0] idx, input logic [21:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		case (idx)
			REG_ZERO_POINT_A: zp_a_copy    = data[7:0];
			REG_SCALE_A:      scale_a_copy = data;
			REG_ZERO_POINT_B: zp_b_copy    = data[7:0];
			REG_SCALE_B:      scale_b_copy = data;
			default:          ;  // Unused indexes leave every register alone.
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic program_all(input logic signed [7:0] zp_a, input logic [21:0] sc_a,
			input logic signed [7:0] zp_b, input logic [21:0] sc_b);
		write_reg(REG_ZERO_POINT_A, {14'd0, zp_a});
		write_reg(REG_SCALE_A, sc_a);
		write_reg(REG_ZERO_POINT_B, {14'd0, zp_b});
		write_reg(REG_SCALE_B, sc_b);
	endtask

	// Sends one element pair request. Valid stays high afterwards, so the next
	// call can follow back to back without a bubble.
	task automatic send_pair(input logic signed [7:0] a, input logic signed [7:0] b,
			input logic last);
		int gap;
		if (idle_enabled && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     = 1'b1;
		a_value      = a;
		b_value      = b;
		last_element = last;
		do
			@(posedge clk);
		while (!in_ready);
		accumulate_pair(a, b, last);
		pairs_sent++;
	endtask

	// Stops sending and waits until every owed dot sum has arrived. Then it lets
	// the block settle, so that a request without a result also finishes.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result checker. It samples the output at each rising edge.
	initial begin
		logic signed [31:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_sums.size() == 0) begin
					report_mismatch($sformatf("dot_sum %0d arrived with none owed", dot_sum));
				end else begin
					want = expected_sums.pop_front();
					if (dot_sum !== want)
						report_mismatch($sformatf("dot_sum got %0d, want %0d", dot_sum, want));
				end
			end
		end
	end

	// Receiver back-pressure. Random stalls come between stretches of readiness,
	// and no new stall starts once idling is switched off.
	initial begin
		int span;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_enabled && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				span = $urandom_range(1, 18);
			end else begin
				out_ready = 1'b1;
				span = $urandom_range(1, 24);
			end
			repeat (span - 1) @(negedge clk);
		end
	end

	// At reset both scales are zero, so any pair adds nothing. The two pairs
	// below also carry the extreme element values.
	task automatic test_zero_scale();
		send_pair(8'sd127, -8'sd128, 1'b0);
		send_pair(-8'sd128, 8'sd127, 1'b1);
		drain_results();
	endtask

	// The extreme element values, each bit of every field, and a pair vector
	// that closes with zero elements.
	task automatic test_field_extremes();
		program_all(8'sd0, 22'd256, 8'sd0, 22'd256);
		send_pair(-8'sd128, -8'sd128, 1'b0);
		send_pair(8'sd127, -8'sd128, 1'b0);
		send_pair(-8'sd128, 8'sd127, 1'b0);
		send_pair(8'sd127, 8'sd127, 1'b1);
		send_pair(8'sd0, 8'sd0, 1'b1);
		drain_results();
	endtask

	// Vectors of a single pair. These are accumulated into the cleared sum and
	// emitted at once. Tiny scales make the shift round a negative term down
	// and a positive one to zero.
	task automatic test_single_pair();
		program_all(8'sd0, 22'd3, 8'sd0, 22'd3);
		send_pair(-8'sd1, 8'sd1, 1'b1);
		send_pair(8'sd1, 8'sd1, 1'b1);
		drain_results();
		program_all(-8'sd3, 22'd65536, 8'sd2, 22'd65536);
		send_pair(8'sd5, -8'sd7, 1'b1);
		drain_results();
	endtask

	// Huge terms at the largest scales must saturate the sum at both bounds.
	// The mid-vector reconfiguration also makes the sender wait for an empty
	// result queue while a partial sum is held.
	task automatic test_large_term();
		program_all(-8'sd128, SCALE_MAX, -8'sd128, SCALE_MAX);
		send_pair(8'sd127, 8'sd127, 1'b0);
		send_pair(8'sd127, 8'sd127, 1'b1);
		send_pair(8'sd127, 8'sd127, 1'b0);
		drain_results();
		// From the upper bound, one negative term must land on the lower bound.
		write_reg(REG_ZERO_POINT_A, {14'd0, 8'sd127});
		send_pair(-8'sd128, 8'sd127, 1'b1);
		send_pair(-8'sd128, 8'sd127, 1'b0);
		send_pair(-8'sd128, 8'sd127, 1'b1);
		drain_results();
	endtask

	// Writes to indexes past the last register must not disturb the others.
	task automatic test_unused_index();
		program_all(8'sd1, 22'd512, -8'sd1, 22'd1024);
		write_reg(REG_UNUSED_LO, 22'(~0));
		write_reg(REG_UNUSED_LO + 3'd3, 22'h2A_AAAA);
		send_pair(8'sd9, -8'sd20, 1'b1);
		drain_results();
	endtask

	function automatic logic [21:0] pick_scale();
		case ($urandom_range(0, 5))
			0:       return 22'd0;
			1:       return SCALE_MAX;
			2:       return 22'($urandom);
			5:       return 22'($urandom_range(1, 65536));
			default: return 22'($urandom_range(1, 4096));
		endcase
	endfunction

	function automatic logic signed [7:0] pick_zero_point();
		case ($urandom_range(0, 4))
			0:       return -8'sd128;
			1:       return 8'sd127;
			2:       return 8'($urandom);
			default: return 8'($urandom_range(0, 16)) - 8'sd8;
		endcase
	endfunction

	// Each phase rewrites a random subset of the registers, now and then with a
	// stray write to an unused index among them.
	task automatic configure_random_phase();
		if ($urandom_range(0, 2) != 0)
			write_reg(REG_ZERO_POINT_A, {14'd0, pick_zero_point()});
		if ($urandom_range(0, 2) != 0)
			write_reg(REG_SCALE_A, pick_scale());
		if ($urandom_range(0, 2) != 0)
			write_reg(REG_ZERO_POINT_B, {14'd0, pick_zero_point()});
		if ($urandom_range(0, 2) != 0)
			write_reg(REG_SCALE_B, pick_scale());
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_UNUSED_LO + 3'($urandom_range(0, 3)), 22'($urandom));
	endtask

	// Random vectors of random length under random configurations.
	// Occasionally a phase ends mid-vector. The partial sum then carries over
	// into the next configuration.
	task automatic test_random_vectors(input int target);
		int vectors;
		int len;
		while (pairs_sent < target) begin
			configure_random_phase();
			vectors = $urandom_range(1, 6);
			for (int v = 0; v < vectors; v++) begin
				gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 199) == 0)
						drain_results();
					send_pair(8'($urandom), 8'($urandom), i == len - 1);
				end
			end
			if ($urandom_range(0, 7) == 0)
				send_pair(8'($urandom), 8'($urandom), 1'b0);
			drain_results();
		end
	endtask

	// Closing stretch with no idling on either side. Requests go back to back
	// while the receiver stays ready.
	task automatic test_back_to_back(input int count);
		int sent;
		idle_enabled = 1'b0;
		program_all(pick_zero_point(), 22'($urandom_range(1, 4096)),
			pick_zero_point(), 22'($urandom_range(1, 4096)));
		sent = 0;
		while (sent < count) begin
			send_pair(8'($urandom), 8'($urandom), $urandom_range(0, 5) == 0);
			sent++;
		end
		send_pair(8'($urandom), 8'($urandom), 1'b1);
	endtask

	initial begin
		error_count  = 0;
		pairs_sent   = 0;
		idle_enabled = 1'b1;
		gap_odds     = 4;
		zp_a_copy    = '0;
		scale_a_copy = '0;
		zp_b_copy    = '0;
		scale_b_copy = '0;
		sum_copy     = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		a_value      = '0;
		b_value      = '0;
		last_element = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_zero_scale();
		test_field_extremes();
		test_single_pair();
		test_large_term();
		test_unused_index();
		test_random_vectors(TOTAL_PAIRS - TAIL_PAIRS);
		drain_results();
		test_back_to_back(TAIL_PAIRS);

		// Wind down. Let the last results come out and the block go quiet.
		drain_results();
		if (error_count == 0)
			$display("[quantized_dot_product_accumulator] OK");
		else
			$display("[quantized_dot_product_accumulator] ERROR");
		$finish;
	end

endmodule
